[src/dpbp_pkg.sv]
package dpbp_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_W        = 16;
    localparam int CENTER_W       = 16;
    localparam int RECIP_W        = 24;
    localparam int RECIP_HALF     = RECIP_W / 2;
    localparam int OUT_W          = 36;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;

    localparam logic [DEPTH_W-1:0] DEPTH_NONE = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_ZERO = '0;

    localparam logic signed [63:0] OUT_MAX = 64'sd34359738367;
    localparam logic signed [63:0] OUT_MIN = -64'sd34359738368;

    localparam logic [RECIP_W-1:0]  INV_FOCAL_X_RST = 24'd31957;
    localparam logic [RECIP_W-1:0]  INV_FOCAL_Y_RST = 24'd31957;
    localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd5112;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3832;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_FOCAL_X = 2'd0,
        CFG_INV_FOCAL_Y = 2'd1,
        CFG_CENTER_X    = 2'd2,
        CFG_CENTER_Y    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

[src/dpbp_pix_if.sv]
interface dpbp_pix_if #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [COORD_BITS-1:0]        pixel_u;
    logic [COORD_BITS-1:0]        pixel_v;
    logic [dpbp_pkg::DEPTH_W-1:0] depth_raw;
    logic                         keep;

    modport source (output valid, pixel_u, pixel_v, depth_raw, keep, input ready);
    modport sink   (input valid, pixel_u, pixel_v, depth_raw, keep, output ready);
endinterface

[src/dpbp_pnt_if.sv]
interface dpbp_pnt_if;
    logic                                valid;
    logic                                ready;
    logic signed [dpbp_pkg::OUT_W-1:0]   point_x;
    logic signed [dpbp_pkg::OUT_W-1:0]   point_y;
    logic        [dpbp_pkg::DEPTH_W-1:0] point_z;
    logic                                valid_res;

    modport source (output valid, point_x, point_y, point_z, valid_res, input ready);
    modport sink   (input valid, point_x, point_y, point_z, valid_res, output ready);
endinterface

[src/dpbp_axis.sv]
module dpbp_axis #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  dpbp_pkg::t_stage_en                 i_en,
    input  logic [COORD_BITS-1:0]               i_pix,
    input  logic [dpbp_pkg::CENTER_W-1:0]       i_center,
    input  logic [dpbp_pkg::DEPTH_W-1:0]        i_z1,
    input  logic [dpbp_pkg::RECIP_W-1:0]        i_recip,
    output logic signed [dpbp_pkg::OUT_W-1:0]   o_coord
);
    localparam int PIX_W = COORD_BITS + 4;
    localparam int D_W   = ((PIX_W > dpbp_pkg::CENTER_W) ? PIX_W : dpbp_pkg::CENTER_W) + 1;
    localparam int A_W   = D_W + dpbp_pkg::DEPTH_W;
    localparam int L_W   = A_W + dpbp_pkg::RECIP_HALF;
    localparam int P_W   = A_W + dpbp_pkg::RECIP_W;

    logic signed [D_W-1:0] r_d;
    logic signed [D_W-1:0] n_d;
    logic signed [A_W-1:0] r_a;
    logic signed [L_W-1:0] r_lo;
    logic signed [L_W-1:0] r_hi;
    logic signed [P_W-1:0] n_p;
    logic signed [A_W-1:0] n_q;
    logic signed [63:0]    n_q64;

    assign n_d = D_W'($signed({1'b0, i_pix, 4'b0000}))
               - D_W'($signed({1'b0, i_center}));

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_d <= n_d;
        end
        if (i_en.s2) begin
            r_a <= A_W'(r_d) * A_W'($signed({1'b0, i_z1}));
        end
        if (i_en.s3) begin
            r_lo <= L_W'(r_a)
                  * L_W'($signed({1'b0, i_recip[dpbp_pkg::RECIP_HALF-1:0]}));
            r_hi <= L_W'(r_a)
                  * L_W'($signed({1'b0, i_recip[dpbp_pkg::RECIP_W-1:dpbp_pkg::RECIP_HALF]}));
        end
    end

    always_comb begin
        n_p   = (P_W'(r_hi) <<< dpbp_pkg::RECIP_HALF) + P_W'(r_lo);
        n_q   = $signed(n_p[P_W-1:dpbp_pkg::RECIP_W]);
        n_q64 = 64'(n_q);
        if (n_q64 > dpbp_pkg::OUT_MAX) begin
            o_coord = dpbp_pkg::OUT_MAX[dpbp_pkg::OUT_W-1:0];
        end else if (n_q64 < dpbp_pkg::OUT_MIN) begin
            o_coord = dpbp_pkg::OUT_MIN[dpbp_pkg::OUT_W-1:0];
        end else begin
            o_coord = n_q64[dpbp_pkg::OUT_W-1:0];
        end
    end

endmodule

[src/depth_pixel_back_projection.sv]
// Back-projects depth pixels through a pinhole camera model into 3-D points.
// i_pix carries requests: pixel column and row, raw depth in millimetres and
// a keep bit. A request with keep clear is taken and yields nothing. A kept
// request yields one point on o_pnt: X and Y in millimetres with 4 fraction
// bits (floor, saturated to 36 bits), Z in millimetres and valid_res. Depth 0
// or all ones gives valid_res low with all coordinates zero.
// The i_cfg_* port writes the two focal reciprocals (2^24 / f) and the
// principal point (sixteenths of a pixel); write only while the block is idle.
// Pipeline: a request passes through four register stages (offset, depth
// multiply, split reciprocal multiply, sum and saturate into the output
// register) before its point is valid on o_pnt. Throughput: one request
// per cycle while the receiver takes points. Each stage has its own valid
// bit and loads whenever the stage after it is empty or moving, so bubbles
// close up and a stalled receiver holds the output register while earlier
// stages fill.
// Reset clears all valid bits and loads the default camera intrinsics.
module depth_pixel_back_projection #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dpbp_pix_if.sink                        i_pix,
    dpbp_pnt_if.source                      o_pnt,
    input  logic                            i_cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [dpbp_pkg::RECIP_W-1:0]  r_inv_fx;
    logic [dpbp_pkg::RECIP_W-1:0]  r_inv_fy;
    logic [dpbp_pkg::CENTER_W-1:0] r_cx;
    logic [dpbp_pkg::CENTER_W-1:0] r_cy;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_bad1, r_bad2, r_bad3;
    logic [dpbp_pkg::DEPTH_W-1:0] r_z1, r_z2, r_z3;

    logic signed [dpbp_pkg::OUT_W-1:0] r_x;
    logic signed [dpbp_pkg::OUT_W-1:0] r_y;
    logic [dpbp_pkg::DEPTH_W-1:0]      r_z;
    logic                              r_vres;

    logic signed [dpbp_pkg::OUT_W-1:0] n_x;
    logic signed [dpbp_pkg::OUT_W-1:0] n_y;

    dpbp_pkg::t_stage_en n_en;
    logic n_en4;
    logic n_take;
    logic n_bad;

    assign n_en4   = !r_v4 || o_pnt.ready;
    assign n_en.s3 = !r_v3 || n_en4;
    assign n_en.s2 = !r_v2 || n_en.s3;
    assign n_en.s1 = !r_v1 || n_en.s2;

    assign i_pix.ready = n_en.s1;
    assign n_take = i_pix.valid && n_en.s1;
    assign n_bad  = (i_pix.depth_raw == dpbp_pkg::DEPTH_ZERO)
                 || (i_pix.depth_raw == dpbp_pkg::DEPTH_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= dpbp_pkg::INV_FOCAL_X_RST;
            r_inv_fy <= dpbp_pkg::INV_FOCAL_Y_RST;
            r_cx     <= dpbp_pkg::CENTER_X_RST;
            r_cy     <= dpbp_pkg::CENTER_Y_RST;
        end else if (i_cfg_we) begin
            unique case (dpbp_pkg::t_cfg_idx'(i_cfg_idx))
                dpbp_pkg::CFG_INV_FOCAL_X: r_inv_fx <= i_cfg_data;
                dpbp_pkg::CFG_INV_FOCAL_Y: r_inv_fy <= i_cfg_data;
                dpbp_pkg::CFG_CENTER_X:    r_cx <= i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                dpbp_pkg::CFG_CENTER_Y:    r_cy <= i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en.s1) begin
                r_v1 <= n_take && i_pix.keep;
            end
            if (n_en.s2) begin
                r_v2 <= r_v1;
            end
            if (n_en.s3) begin
                r_v3 <= r_v2;
            end
            if (n_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en.s1) begin
            r_z1   <= i_pix.depth_raw;
            r_bad1 <= n_bad;
        end
        if (n_en.s2) begin
            r_z2   <= r_z1;
            r_bad2 <= r_bad1;
        end
        if (n_en.s3) begin
            r_z3   <= r_z2;
            r_bad3 <= r_bad2;
        end
        if (n_en4) begin
            r_x    <= r_bad3 ? '0 : n_x;
            r_y    <= r_bad3 ? '0 : n_y;
            r_z    <= r_bad3 ? '0 : r_z3;
            r_vres <= !r_bad3;
        end
    end

    dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_pix    (i_pix.pixel_u),
        .i_center (r_cx),
        .i_z1     (r_z1),
        .i_recip  (r_inv_fx),
        .o_coord  (n_x)
    );

    dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_pix    (i_pix.pixel_v),
        .i_center (r_cy),
        .i_z1     (r_z1),
        .i_recip  (r_inv_fy),
        .o_coord  (n_y)
    );

    assign o_pnt.valid     = r_v4;
    assign o_pnt.point_x   = r_x;
    assign o_pnt.point_y   = r_y;
    assign o_pnt.point_z   = r_z;
    assign o_pnt.valid_res = r_vres;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_vres) |-> (r_x == '0 && r_y == '0 && r_z == '0))
        else $error("invalid point carries nonzero coordinates");

    a_good_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_vres) |-> (r_z != dpbp_pkg::DEPTH_ZERO && r_z != dpbp_pkg::DEPTH_NONE))
        else $error("usable point carries a no-reading depth");

    a_keep_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && i_pix.keep) |=> (r_v1 && r_bad1 == $past(n_bad)))
        else $error("kept request did not enter the first stage");

    a_drop_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && !i_pix.keep) |=> !r_v1)
        else $error("masked request entered the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (!r_v4 || o_pnt.ready)) |=> r_v4)
        else $error("point lost between last stage and output");

endmodule
